[rtl/wrna_pkg.sv]
`default_nettype none

package wrna_pkg;

  localparam int WordW    = 64;
  localparam int FracBits = 32;
  localparam int ExpW     = WordW - FracBits;
  localparam int MantW    = FracBits + 1;
  localparam int AddLimit = 54;
  localparam int ShiftW   = $clog2(AddLimit + 1);
  localparam int QDepth   = 2;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int QCntW    = $clog2(QDepth + 1);

  localparam logic [1:0] OpLoad = 2'd0;
  localparam logic [1:0] OpAdd  = 2'd1;
  localparam logic [1:0] OpMul  = 2'd2;

  typedef enum logic [1:0] {
    KindLoad,
    KindAdd,
    KindMul,
    KindHold
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [WordW-1:0]   value;
  } item_t;

endpackage

`default_nettype wire

[rtl/wrna_front.sv]
`default_nettype none

module wrna_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [1:0]                     op_i,
  input  wire logic [wrna_pkg::WordW-1:0]     value_i,
  output logic                                q_valid_o,
  output wrna_pkg::item_t                     q_item_o,
  input  wire logic                           q_pop_i
);

  wrna_pkg::item_t                  mem_q [wrna_pkg::QDepth];
  wrna_pkg::item_t                  item_in;
  logic [wrna_pkg::QPtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [wrna_pkg::QPtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [wrna_pkg::QCntW-1:0]       cnt_q, cnt_d;
  logic                             push;

  always_comb begin
    item_in.value = value_i;
    case (op_i)
      wrna_pkg::OpLoad: item_in.kind = wrna_pkg::KindLoad;
      wrna_pkg::OpAdd:  item_in.kind = wrna_pkg::KindAdd;
      wrna_pkg::OpMul:  item_in.kind = wrna_pkg::KindMul;
      default:          item_in.kind = wrna_pkg::KindHold;
    endcase
  end

  assign in_ready_o = (cnt_q != wrna_pkg::QCntW'(wrna_pkg::QDepth));
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (q_pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

`default_nettype wire

[rtl/wrna_back.sv]
`default_nettype none

module wrna_back (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           q_valid_i,
  input  wire wrna_pkg::item_t                q_item_i,
  output logic                                q_pop_o,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [wrna_pkg::WordW-1:0]          result_o,
  output logic                                overflow_o
);

  localparam int EW = wrna_pkg::ExpW;
  localparam int FB = wrna_pkg::FracBits;
  localparam int MW = wrna_pkg::MantW;
  localparam int WW = wrna_pkg::WordW;
  localparam int SW = wrna_pkg::ShiftW;

  localparam logic signed [EW+1:0] EMax = {3'b000, {(EW-1){1'b1}}};
  localparam logic signed [EW+1:0] EMin = ~EMax;
  localparam logic signed [EW:0]   DLim = (EW+1)'(wrna_pkg::AddLimit);
  localparam logic [WW-1:0]        SatHi = {1'b0, {(WW-1){1'b1}}};
  localparam logic [WW-1:0]        SatLo = {1'b1, {(WW-1){1'b0}}};

  typedef struct packed {
    logic [WW-1:0] word;
    logic          ovf;
  } res_t;

  function automatic res_t compose_fn(input logic signed [EW+1:0] e, input logic [MW:0] m);
    res_t                    r;
    logic signed [EW+1:0]    en;
    logic [FB-1:0]           f;
    en = e;
    f  = m[FB-1:0];
    if (m[MW]) begin
      en = e + (EW+2)'(1);
      f  = m[FB:1];
    end
    r.ovf  = 1'b0;
    r.word = {en[EW-1:0], f};
    if (en > EMax) begin
      r.ovf  = 1'b1;
      r.word = SatHi;
    end else if (en < EMin) begin
      r.ovf  = 1'b1;
      r.word = SatLo;
    end
    return r;
  endfunction

  logic [WW-1:0]          acc_q, acc_d;
  logic                   out_valid_q;
  logic [WW-1:0]          result_q;
  logic                   overflow_q;

  logic [WW-1:0]          b;
  logic signed [EW-1:0]   ea, eb;
  logic [FB-1:0]          fa, fb;
  logic [MW-1:0]          ma, mb, sa, sb;
  logic signed [EW:0]     d, nd;
  logic                   keep_a, take_b;
  logic signed [EW+1:0]   e_add, e_mul;
  logic [MW:0]            sum;
  logic [2*MW-1:0]        prod;
  res_t                   add_r, mul_r, step_r;

  assign b  = q_item_i.value;
  assign ea = acc_q[WW-1:FB];
  assign eb = b[WW-1:FB];
  assign fa = acc_q[FB-1:0];
  assign fb = b[FB-1:0];
  assign ma = {1'b1, fa};
  assign mb = {1'b1, fb};
  assign d  = {ea[EW-1], ea} - {eb[EW-1], eb};
  assign nd = -d;

  assign keep_a = (d > DLim) || ((d == DLim) && (fa > fb));
  assign take_b = (d < -DLim) || ((d == -DLim) && (fa < fb));

  always_comb begin
    if (!d[EW]) begin
      sa    = ma;
      sb    = mb >> d[SW-1:0];
      e_add = {{2{ea[EW-1]}}, ea};
    end else begin
      sa    = ma >> nd[SW-1:0];
      sb    = mb;
      e_add = {{2{eb[EW-1]}}, eb};
    end
  end

  assign sum   = {1'b0, sa} + {1'b0, sb};
  assign prod  = ma * mb;
  assign e_mul = {{2{ea[EW-1]}}, ea} + {{2{eb[EW-1]}}, eb};

  always_comb begin
    add_r = compose_fn(e_add, sum);
    if (keep_a) begin
      add_r = '{word: acc_q, ovf: 1'b0};
    end else if (take_b) begin
      add_r = '{word: b, ovf: 1'b0};
    end
    mul_r = compose_fn(e_mul, prod[FB +: MW+1]);
  end

  always_comb begin
    case (q_item_i.kind)
      wrna_pkg::KindLoad: step_r = '{word: b, ovf: 1'b0};
      wrna_pkg::KindAdd:  step_r = add_r;
      wrna_pkg::KindMul:  step_r = mul_r;
      default:            step_r = '{word: acc_q, ovf: 1'b0};
    endcase
  end

  assign q_pop_o = q_valid_i && (!out_valid_q || out_ready_i);
  assign acc_d   = q_pop_o ? step_r.word : acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      if (q_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      result_q   <= step_r.word;
      overflow_q <= step_r.ovf;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;
  assign overflow_o  = overflow_q;

endmodule

`default_nettype wire

[rtl/wide_range_number_accumulator.sv]
// Channel | Signals                                   | Direction
// in      | in_valid_i, in_ready_o, op_i, value_i     | into block
// out     | out_valid_o, out_ready_i, result_o,       | out of block
//         | overflow_o                                |
//
// One item per cycle while out_ready_i stays high; an item goes into the queue,
// then its result into the output register. The accumulator update loop sets
// the rate (exponent align, shift, add or 33x33 multiply, normalize).
// Reset clears the accumulator to zero (one point zero) and empties the queue.
// A 2-beat queue sits between decode and execute; in_ready_o drops only
// when it is full, and the output register holds while out_ready_i is low.
`default_nettype none

module wide_range_number_accumulator (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [1:0]           op_i,
  input  wire logic signed [63:0]   value_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic signed [63:0]        result_o,
  output logic                      overflow_o
);

  logic                                  q_valid;
  logic                                  q_pop;
  wrna_pkg::item_t                       q_item;
  logic [wrna_pkg::WordW-1:0]            result;

  wrna_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .value_i    (value_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  wrna_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result),
    .overflow_o  (overflow_o)
  );

  assign result_o = result;

endmodule

`default_nettype wire

[dv/wide_range_number_accumulator_checker.sv]
`timescale 1ns / 1ps

module wide_range_number_accumulator_checker
  import wrna_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [1:0]        op_i,
  input  logic [WordW-1:0]  value_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [WordW-1:0]  result_i,
  input  logic              overflow_i,
  output int                errors_o,
  output int                pending_o
);

  typedef struct packed {
    logic [WordW-1:0] word;
    logic             ovf;
  } acc_update_t;

  acc_update_t      pending_results[$];
  logic [WordW-1:0] acc_word;
  int               fail_count;

  assign errors_o = fail_count;

  function automatic longint exponent_of(logic [WordW-1:0] w);
    return longint'($signed(w[WordW-1:FracBits]));
  endfunction

  // Mantissa in [1,4): halve once if needed, then saturate the exponent.
  function automatic acc_update_t pack_word(longint e, logic [63:0] m);
    acc_update_t r;
    longint      emax;
    longint      emin;
    emax = (longint'(1) <<< (ExpW - 1)) - 1;
    emin = -emax - 1;
    if (m >= (64'd2 << FracBits)) begin
      m = m >> 1;
      e = e + 1;
    end
    r.ovf = 1'b0;
    if (e > emax) begin
      r.word = {1'b0, {(WordW-1){1'b1}}};
      r.ovf  = 1'b1;
    end else if (e < emin) begin
      r.word = {1'b1, {(WordW-1){1'b0}}};
      r.ovf  = 1'b1;
    end else begin
      r.word = {e[ExpW-1:0], m[FracBits-1:0]};
    end
    return r;
  endfunction

  function automatic acc_update_t log_sum(logic [WordW-1:0] a, logic [WordW-1:0] b);
    acc_update_t         r;
    longint              ea;
    longint              eb;
    longint              d;
    longint              e;
    logic [FracBits-1:0] fa;
    logic [FracBits-1:0] fb;
    logic [63:0]         ma;
    logic [63:0]         mb;
    ea = exponent_of(a);
    eb = exponent_of(b);
    d  = ea - eb;
    fa = a[FracBits-1:0];
    fb = b[FracBits-1:0];
    r.ovf = 1'b0;
    if (d > AddLimit || (d == AddLimit && fa > fb)) begin
      r.word = a;
      return r;
    end
    if (d <= -AddLimit - 1 || (d == -AddLimit && fa < fb)) begin
      r.word = b;
      return r;
    end
    ma = (64'd1 << FracBits) | 64'(fa);
    mb = (64'd1 << FracBits) | 64'(fb);
    if (d >= 0) begin
      mb = mb >> d;
      e  = ea;
    end else begin
      ma = ma >> (-d);
      e  = eb;
    end
    return pack_word(e, ma + mb);
  endfunction

  function automatic acc_update_t log_product(logic [WordW-1:0] a, logic [WordW-1:0] b);
    logic [MantW-1:0]   ma;
    logic [MantW-1:0]   mb;
    logic [2*MantW-1:0] prod;
    ma   = {1'b1, a[FracBits-1:0]};
    mb   = {1'b1, b[FracBits-1:0]};
    prod = (2*MantW)'(ma) * (2*MantW)'(mb);
    return pack_word(exponent_of(a) + exponent_of(b), 64'(prod >> FracBits));
  endfunction

  task automatic report_mismatch(string what, logic [WordW-1:0] got, logic [WordW-1:0] want);
    $display("%0t: %s mismatch: got %h, expected %h", $time, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending_o  = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    acc_update_t upd;
    acc_update_t want;
    if (!rst_ni) begin
      acc_word = '0;
      pending_results.delete();
      pending_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        case (op_i)
          OpLoad: upd = '{word: value_i, ovf: 1'b0};
          OpAdd:  upd = log_sum(acc_word, value_i);
          OpMul:  upd = log_product(acc_word, value_i);
          default: upd = '{word: acc_word, ovf: 1'b0};
        endcase
        acc_word = upd.word;
        pending_results.push_back(upd);
      end
      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unrequested beat", result_i, '0);
        end else begin
          want = pending_results.pop_front();
          if (result_i !== want.word) report_mismatch("result", result_i, want.word);
          if (overflow_i !== want.ovf) report_mismatch("overflow", 64'(overflow_i), 64'(want.ovf));
        end
      end
      pending_o = pending_results.size();
    end
  end

endmodule

[dv/wide_range_number_accumulator_test.sv]
`timescale 1ns / 1ps

module wide_range_number_accumulator_test;
  import wrna_pkg::*;

  localparam logic [1:0] OpSpare    = 2'd3;
  localparam int         CycleLimit = 200000;
  localparam int         PhaseBeats = 500;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    out_ready_i = 1'b0;
  logic [1:0]              op_i        = OpLoad;
  logic signed [WordW-1:0] value_i     = '0;
  logic                    in_ready_o;
  logic                    out_valid_o;
  logic signed [WordW-1:0] result_o;
  logic                    overflow_o;

  int errors;
  int pending;
  int cycles        = 0;
  int send_idle_pct = 21;
  int recv_idle_pct = 53;

  wide_range_number_accumulator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result_o),
    .overflow_o  (overflow_o)
  );

  wide_range_number_accumulator_checker checker_u (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .op_i        (op_i),
    .value_i     (value_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_i    (result_o),
    .overflow_i  (overflow_o),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("wide_range_number_accumulator_test NOT OK");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic [WordW-1:0] word_of(longint e, logic [FracBits-1:0] f);
    return {e[ExpW-1:0], f};
  endfunction

  function automatic logic [WordW-1:0] random_word();
    longint              e;
    logic [FracBits-1:0] f;
    case ($urandom_range(2))
      0:       f = '0;
      1:       f = '1;
      default: f = FracBits'($urandom);
    endcase
    if ($urandom_range(2) != 0) f = FracBits'($urandom);
    case ($urandom_range(9))
      0: return {$urandom, $urandom};
      1: begin
        if ($urandom_range(1) != 0) e = (longint'(1) <<< (ExpW - 1)) - 1 - $urandom_range(3);
        else e = -(longint'(1) <<< (ExpW - 1)) + $urandom_range(3);
      end
      default: e = longint'($urandom_range(140)) - 70;
    endcase
    return word_of(e, f);
  endfunction

  // Valid stays up between back-to-back beats; only one drive per step.
  task automatic send_beat(logic [1:0] op, logic [WordW-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    value_i    <= value;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic random_phase(int beats);
    int r;
    for (int i = 0; i < beats; i++) begin
      r = $urandom_range(99);
      if (r < 12) send_beat(OpLoad, random_word());
      else if (r < 50) send_beat(OpAdd, random_word());
      else if (r < 92) send_beat(OpMul, random_word());
      else send_beat(OpSpare, random_word());
    end
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_beat(OpSpare, random_word());
    send_beat(OpLoad, {1'b0, {(WordW-1){1'b1}}});
    send_beat(OpAdd, {1'b0, {(WordW-1){1'b1}}});
    send_beat(OpLoad, {1'b1, {(WordW-1){1'b0}}});
    send_beat(OpMul, word_of(-1, '0));
    send_beat(OpLoad, word_of(0, '0));
    send_beat(OpAdd, word_of(0, '0));
    send_beat(OpLoad, word_of(AddLimit, 32'h8000_0000));
    send_beat(OpAdd, word_of(0, 32'h1));
    send_beat(OpLoad, word_of(AddLimit, 32'h1));
    send_beat(OpAdd, word_of(0, 32'h8000_0000));
    send_beat(OpLoad, word_of(-AddLimit, 32'h1));
    send_beat(OpAdd, word_of(0, '0));
    send_beat(OpLoad, word_of(-AddLimit, '0));
    send_beat(OpAdd, word_of(0, '1));
    send_beat(OpLoad, word_of(-AddLimit - 1, '0));
    send_beat(OpAdd, word_of(0, '0));
    send_beat(OpLoad, word_of(100, 32'h1234_5678));
    send_beat(OpAdd, word_of(0, 32'h9abc_def0));
    send_beat(OpLoad, word_of(3, '1));
    send_beat(OpMul, word_of(-2, '1));
    send_beat(OpMul, word_of((longint'(1) <<< (ExpW - 1)) - 1, '0));
    send_beat(OpSpare, '0);
    send_beat(OpLoad, '1);
    send_beat(OpMul, '1);
    drain();

    random_phase(PhaseBeats);
    drain();
    send_idle_pct = 53;
    recv_idle_pct = 21;
    random_phase(PhaseBeats);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(PhaseBeats);
    drain();
    repeat (8) @(negedge clk_i);

    if (errors == 0 && pending == 0) begin
      $display("wide_range_number_accumulator_test OK");
    end else begin
      $display("wide_range_number_accumulator_test NOT OK");
    end
    $finish;
  end

endmodule
